// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication, masked while reset is asserted.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== rtl/pmra_pkg.sv =====
// Types and constants for the priority mask register allocator.
package pmra_pkg;

    localparam int REG_COUNT  = 32;
    localparam int SPILL_BITS = 16;

    // Registers that carry a busy bit and class bits.
    localparam int BIT_REGS = (REG_COUNT < 32) ? REG_COUNT : 32;
    localparam int IDX_W    = 5;
    localparam int TGT_W    = 6;
    localparam int CNT_W    = 6;
    localparam int MASK_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [MASK_W-1:0] VALID_REGS =
        (BIT_REGS >= 32) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << BIT_REGS) - 64'd1);
    localparam logic [SPILL_BITS-1:0] SPILL_MAX = {SPILL_BITS{1'b1}};
    localparam logic [TGT_W-1:0] TGT_LIMIT = TGT_W'(BIT_REGS);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CALLER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CALLEE = CFG_IDX_W'(1);

    typedef struct packed {
        logic [MASK_W-1:0] caller;
        logic [MASK_W-1:0] callee;
    } t_masks;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_pick;

endpackage

// ===== rtl/pmra_cfg.sv =====
// Class mask registers written through the configuration channel.
module pmra_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pmra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pmra_pkg::MASK_W-1:0]      i_cfg_data,
    output pmra_pkg::t_masks                 o_masks
);

    pmra_pkg::t_masks r_masks;

    assign o_cfg_ready = 1'b1;
    assign o_masks     = r_masks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pmra_pkg::CFG_CALLER: r_masks.caller <= i_cfg_data;
                pmra_pkg::CFG_CALLEE: r_masks.callee <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/pmra_pick.sv =====
// Two-level priority pick: lowest free register in the preferred class, else the other.
module pmra_pick (
    input  pmra_pkg::t_masks                 i_masks,
    input  logic                             i_prefer_caller,
    input  logic [pmra_pkg::MASK_W-1:0]      i_busy_bits,
    output pmra_pkg::t_pick                  o_pick
);

    logic [pmra_pkg::MASK_W-1:0] free_set;
    logic [pmra_pkg::MASK_W-1:0] first_cand;
    logic [pmra_pkg::MASK_W-1:0] second_cand;
    logic [pmra_pkg::MASK_W-1:0] cand;
    logic [pmra_pkg::MASK_W-1:0] low_hot;
    logic [pmra_pkg::IDX_W-1:0]  idx;

    assign free_set    = ~i_busy_bits & pmra_pkg::VALID_REGS;
    assign first_cand  = free_set & (i_prefer_caller ? i_masks.caller : i_masks.callee);
    assign second_cand = free_set & (i_prefer_caller ? i_masks.callee : i_masks.caller);
    assign cand        = (|first_cand) ? first_cand : second_cand;
    // isolate the lowest set bit
    assign low_hot     = cand & (~cand + pmra_pkg::MASK_W'(1));

    always_comb begin
        idx = '0;
        for (int i = 0; i < pmra_pkg::MASK_W; i++) begin
            if (low_hot[i]) begin
                idx = idx | pmra_pkg::IDX_W'(i);
            end
        end
    end

    assign o_pick.found = |cand;
    assign o_pick.idx   = idx;

endmodule

// ===== rtl/priority_mask_register_allocator.sv =====
// Top level: input register, allocator state and result register.
// A taken command passes the input register, then the result register, which drives its result strobe.
// Throughput: one command per cycle outside reset; the pick and counter update run in one stage.
// The stage reads state left by the previous command, updated at the same edge.
// Reset (synchronous, active low) clears masks, busy bitmap and all counters.
// Results cannot be stalled by the receiver; o_busy is high only during reset.
`include "assert_macros.svh"
module priority_mask_register_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [1:0]                       i_opcode,
    input  logic                             i_prefer_caller_class,
    input  logic [pmra_pkg::TGT_W-1:0]       i_target_reg,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pmra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pmra_pkg::MASK_W-1:0]      i_cfg_data,
    output logic                             o_strobe,
    output logic [pmra_pkg::IDX_W-1:0]       o_granted_reg,
    output logic                             o_grant_valid,
    output logic                             o_busy_flag,
    output logic [pmra_pkg::CNT_W-1:0]       o_in_use_count,
    output logic [pmra_pkg::CNT_W-1:0]       o_peak_in_use,
    output logic [pmra_pkg::SPILL_BITS-1:0]  o_spill_total
);

    pmra_pkg::t_masks masks;
    pmra_pkg::t_pick  pick;

    // input register
    logic                            r_stg_vld;
    logic [1:0]                      r_op;
    logic                            r_pref;
    logic [pmra_pkg::TGT_W-1:0]      r_tgt;

    // allocator state
    logic [pmra_pkg::MASK_W-1:0]     r_busy_bits, n_busy_bits;
    logic [pmra_pkg::CNT_W-1:0]      r_in_use, n_in_use;
    logic [pmra_pkg::CNT_W-1:0]      r_peak, n_peak;
    logic [pmra_pkg::SPILL_BITS-1:0] r_spills, n_spills;

    // result register
    logic                            r_strobe;
    logic [pmra_pkg::IDX_W-1:0]      r_granted, n_granted;
    logic                            r_gvalid, n_gvalid;
    logic                            r_bflag, n_bflag;

    logic                            accept;
    logic                            tgt_ok;
    logic                            tgt_busy;
    logic [pmra_pkg::IDX_W-1:0]      tgt_idx;

    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    pmra_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_masks     (masks)
    );

    pmra_pick u_pick (
        .i_masks         (masks),
        .i_prefer_caller (r_pref),
        .i_busy_bits     (r_busy_bits),
        .o_pick          (pick)
    );

    assign tgt_ok   = r_tgt < pmra_pkg::TGT_LIMIT;
    assign tgt_idx  = r_tgt[pmra_pkg::IDX_W-1:0];
    assign tgt_busy = tgt_ok && r_busy_bits[tgt_idx];

    always_comb begin
        n_busy_bits = r_busy_bits;
        n_in_use    = r_in_use;
        n_peak      = r_peak;
        n_spills    = r_spills;
        n_granted   = '0;
        n_gvalid    = 1'b0;
        n_bflag     = 1'b0;
        if (r_stg_vld) begin
            case (r_op)
                pmra_pkg::OP_ALLOC: begin
                    if (pick.found) begin
                        n_busy_bits[pick.idx] = 1'b1;
                        n_in_use  = r_in_use + pmra_pkg::CNT_W'(1);
                        n_granted = pick.idx;
                        n_gvalid  = 1'b1;
                        if (n_in_use > r_peak) begin
                            n_peak = n_in_use;
                        end
                    end else if (r_spills != pmra_pkg::SPILL_MAX) begin
                        n_spills = r_spills + pmra_pkg::SPILL_BITS'(1);
                    end
                end
                pmra_pkg::OP_FREE: begin
                    if (tgt_busy) begin
                        n_busy_bits[tgt_idx] = 1'b0;
                        n_in_use = r_in_use - pmra_pkg::CNT_W'(1);
                    end
                end
                pmra_pkg::OP_QUERY: begin
                    n_bflag = tgt_busy;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld   <= 1'b0;
            r_strobe    <= 1'b0;
            r_busy_bits <= '0;
            r_in_use    <= '0;
            r_peak      <= '0;
            r_spills    <= '0;
        end else begin
            r_stg_vld   <= accept;
            r_strobe    <= r_stg_vld;
            r_busy_bits <= n_busy_bits;
            r_in_use    <= n_in_use;
            r_peak      <= n_peak;
            r_spills    <= n_spills;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_pref <= i_prefer_caller_class;
            r_tgt  <= i_target_reg;
        end
        r_granted <= n_granted;
        r_gvalid  <= n_gvalid;
        r_bflag   <= n_bflag;
    end

    // counters are shown straight from state: they hold until the next transaction
    assign o_strobe       = r_strobe;
    assign o_granted_reg  = r_granted;
    assign o_grant_valid  = r_gvalid;
    assign o_busy_flag    = r_bflag;
    assign o_in_use_count = r_in_use;
    assign o_peak_in_use  = r_peak;
    assign o_spill_total  = r_spills;

    `ASSERT_IMPL(a_strobe_follows, r_stg_vld, ##1 o_strobe, "strobe missing after stage")
    `ASSERT_CLK(a_count_matches, $countones(r_busy_bits) == r_in_use, "in-use count off bitmap")
    `ASSERT_CLK(a_peak_bound, r_peak >= r_in_use, "peak below in-use count")
    `ASSERT_IMPL(a_grant_marked, o_grant_valid, o_strobe && r_busy_bits[o_granted_reg],
        "granted register not marked busy")

endmodule
